/* rtl/crt_pkg.sv */
// Package for the class route table: opcodes, default sizes and beat widths.
// Used by crt_entry_store and class_route_table_unit; depends on nothing else.
package crt_pkg;

  // Default table sizes, handed to the top level parameters.
  localparam int CLASS_COUNT_DEF = 64;
  localparam int TILE_COUNT_DEF  = 16;

  // Field widths of the stream beats.
  localparam int CLS_W   = 8;
  localparam int TILE_IN_W = 8;
  localparam int CONF_W  = 17;
  localparam int CNT32_W = 32;
  localparam int TOTAL_W = 34;
  localparam int VCNT_W  = 7;
  localparam int TOUT_W  = 4;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 176;

  localparam logic [CNT32_W-1:0] CNT_MAX = '1;

  // Operation carried in the slave tuser field.
  typedef enum logic [2:0] {
    OP_LOOKUP         = 3'd0,
    OP_WRITE_ENTRY    = 3'd1,
    OP_CLEAR_ENTRY    = 3'd2,
    OP_CLEAR_ALL      = 3'd3,
    OP_RESET_COUNTERS = 3'd4,
    OP_READ_STATS     = 3'd5,
    OP_END_PASS       = 3'd6
  } crt_op_t;

  // Table update command issued when the decode stage retires a beat.
  typedef struct packed {
    logic wr_en;
    logic clr_en;
    logic clr_all;
  } crt_cmd_t;

endpackage

/* rtl/class_route_table_unit.sv */
// An accepted slave beat passes the decode register, then the output register.
// Throughput: one beat per cycle while the master side does not stall; the entry
// memory is read as the beat is accepted and written as it retires, with a
// forward path for back-to-back accesses to the same class.
// Reset (rst, synchronous) clears all valid bits, the statistics counters,
// the valid count, the version counter and both pipeline stages.
// Top level of the class route table; depends on crt_pkg and crt_entry_store.
module class_route_table_unit
  import crt_pkg::*;
#(
  parameter int CLASS_COUNT = CLASS_COUNT_DEF,
  parameter int TILE_COUNT  = TILE_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // [7:0] class_index, [15:8] tile_index, [32:16] confidence, [39:33] zero
  input  logic [IN_W-1:0]  s_tdata,
  // [2:0] opcode
  input  logic [2:0]       s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // [3:0] tile_out, [4] compiled_route, [5] op_error, [37:6] hit_count,
  // [69:38] miss_count, [101:70] fallback_count, [135:102] total_count,
  // [142:136] valid_entries, [174:143] table_version, [175] zero
  output logic [OUT_W-1:0] m_tdata
);

  localparam int IDX_W  = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int TILE_W = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
  localparam int CNT_W  = $clog2(CLASS_COUNT + 1);

  // Decode stage registers.
  logic                 s1_full;
  crt_op_t              s1_op;
  logic [CLS_W-1:0]     s1_cls;
  logic [TILE_IN_W-1:0] s1_tile;
  logic [CONF_W-1:0]    s1_conf;

  // Statistics.
  logic [CNT32_W-1:0] hits, misses, fallbacks, version;
  logic [TOTAL_W-1:0] total;
  logic [CNT32_W-1:0] hits_next, misses_next, fallbacks_next, version_next;
  logic [TOTAL_W-1:0] total_next;

  logic              s1_fire, accept;
  logic [CLS_W-1:0]  in_cls;
  logic              in_range, tile_ok;
  logic              lk_fb, lk_hit, lk_miss, wr_err;
  logic              cnt_step;
  crt_cmd_t          cmd;
  logic              ent_valid;
  logic [TILE_W-1:0] ent_tile;
  logic [CONF_W-1:0] ent_thresh;
  logic [CNT_W-1:0]  valid_total_next;
  logic [TOUT_W-1:0] tile_res;
  logic              routed;

  assign s1_fire  = s1_full && (!m_tvalid || m_tready);
  assign s_tready = !s1_full || s1_fire;
  assign accept   = s_tvalid && s_tready;
  assign in_cls   = s_tdata[CLS_W-1:0];

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_full <= 1'b0;
    end else if (s_tready) begin
      s1_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= crt_op_t'(s_tuser);
      s1_cls  <= in_cls;
      s1_tile <= s_tdata[15:8];
      s1_conf <= s_tdata[32:16];
    end
  end

  // Range checks and lookup outcome.
  assign in_range = {1'b0, s1_cls} < 9'(CLASS_COUNT);
  assign tile_ok  = {1'b0, s1_tile} < 9'(TILE_COUNT);
  assign lk_fb    = !in_range || !ent_valid;
  assign lk_hit   = !lk_fb && (s1_conf >= ent_thresh);
  assign lk_miss  = !lk_fb && !lk_hit;

  // Operation decode.
  always_comb begin
    cmd            = '0;
    wr_err         = 1'b0;
    routed         = 1'b0;
    hits_next      = hits;
    misses_next    = misses;
    fallbacks_next = fallbacks;
    version_next   = version;
    cnt_step       = 1'b0;
    total_next     = total;
    unique case (s1_op)
      OP_LOOKUP: begin
        if (lk_hit) begin
          routed    = 1'b1;
          cnt_step  = (hits != CNT_MAX);
          hits_next = cnt_step ? hits + 32'd1 : hits;
        end else if (lk_miss) begin
          cnt_step    = (misses != CNT_MAX);
          misses_next = cnt_step ? misses + 32'd1 : misses;
        end else begin
          cnt_step       = (fallbacks != CNT_MAX);
          fallbacks_next = cnt_step ? fallbacks + 32'd1 : fallbacks;
        end
        total_next = cnt_step ? total + TOTAL_W'(1) : total;
      end
      OP_WRITE_ENTRY: begin
        wr_err    = !in_range || !tile_ok;
        cmd.wr_en = s1_fire && !wr_err;
      end
      OP_CLEAR_ENTRY: begin
        cmd.clr_en = s1_fire && in_range;
      end
      OP_CLEAR_ALL: begin
        cmd.clr_all  = s1_fire;
        version_next = version + 32'd1;
      end
      OP_RESET_COUNTERS: begin
        hits_next      = '0;
        misses_next    = '0;
        fallbacks_next = '0;
        total_next     = '0;
      end
      OP_END_PASS: begin
        version_next = version + 32'd1;
      end
      default: begin
      end
    endcase
  end

  assign tile_res = routed ? TOUT_W'(ent_tile) : '0;

  crt_entry_store #(
    .CLASS_COUNT (CLASS_COUNT),
    .TILE_COUNT  (TILE_COUNT)
  ) u_store (
    .clk              (clk),
    .rst              (rst),
    .rd_en            (accept),
    .rd_addr          (in_cls[IDX_W-1:0]),
    .cmd              (cmd),
    .s1_addr          (s1_cls[IDX_W-1:0]),
    .wr_tile          (s1_tile[TILE_W-1:0]),
    .wr_thresh        (s1_conf),
    .ent_valid        (ent_valid),
    .ent_tile         (ent_tile),
    .ent_thresh       (ent_thresh),
    .valid_total_next (valid_total_next)
  );

  // Statistics update as a beat retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      hits      <= '0;
      misses    <= '0;
      fallbacks <= '0;
      total     <= '0;
      version   <= '0;
    end else if (s1_fire) begin
      hits      <= hits_next;
      misses    <= misses_next;
      fallbacks <= fallbacks_next;
      total     <= total_next;
      version   <= version_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      m_tdata <= {1'b0, version_next, VCNT_W'(valid_total_next), total_next,
                  fallbacks_next, misses_next, hits_next, wr_err, routed, tile_res};
    end
  end

  // The running total always equals the sum of the three counters.
  a_total_sum: assert property (@(posedge clk) disable iff (rst)
    total == TOTAL_W'(hits) + TOTAL_W'(misses) + TOTAL_W'(fallbacks))
    else $error("running total differs from counter sum");

  // End of pass advances the version by one.
  a_end_pass: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_op == OP_END_PASS |=> version == $past(version) + 32'd1)
    else $error("end of pass did not advance the version");

  // Counter reset clears all three counters.
  a_cnt_reset: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_op == OP_RESET_COUNTERS |=> hits == '0 && misses == '0 && fallbacks == '0)
    else $error("counter reset left a counter nonzero");

  // A routed lookup bumps the hit counter unless it is saturated.
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_op == OP_LOOKUP && lk_hit |=>
      hits == $past(hits) + 32'd1 || hits == CNT_MAX)
    else $error("hit not counted");

endmodule

/* rtl/crt_entry_store.sv */
// Entry storage for the class route table: tile/threshold memory with a
// registered read and write bypass, valid bits and the running valid count.
// Depends on crt_pkg.
module crt_entry_store
  import crt_pkg::*;
#(
  parameter int CLASS_COUNT = CLASS_COUNT_DEF,
  parameter int TILE_COUNT  = TILE_COUNT_DEF,
  localparam int IDX_W  = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1,
  localparam int TILE_W = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1,
  localparam int CNT_W  = $clog2(CLASS_COUNT + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  input  crt_cmd_t          cmd,
  input  logic [IDX_W-1:0]  s1_addr,
  input  logic [TILE_W-1:0] wr_tile,
  input  logic [CONF_W-1:0] wr_thresh,
  output logic              ent_valid,
  output logic [TILE_W-1:0] ent_tile,
  output logic [CONF_W-1:0] ent_thresh,
  output logic [CNT_W-1:0]  valid_total_next
);

  logic [TILE_W-1:0]      mem_tile [CLASS_COUNT];
  logic [CONF_W-1:0]      mem_thresh [CLASS_COUNT];
  logic [TILE_W-1:0]      rd_tile;
  logic [CONF_W-1:0]      rd_thresh;
  logic                   byp;
  logic [TILE_W-1:0]      byp_tile;
  logic [CONF_W-1:0]      byp_thresh;
  logic [CLASS_COUNT-1:0] valid_bits;
  logic [CNT_W-1:0]       valid_total;
  logic                   cur_valid;

  // Memory write when a write beat retires.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_tile[s1_addr]   <= wr_tile;
      mem_thresh[s1_addr] <= wr_thresh;
    end
  end

  // Registered read for the beat entering the decode stage.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_tile   <= mem_tile[rd_addr];
      rd_thresh <= mem_thresh[rd_addr];
    end
  end

  // A write retiring in the same cycle as the read is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp        <= cmd.wr_en && (rd_addr == s1_addr);
      byp_tile   <= wr_tile;
      byp_thresh <= wr_thresh;
    end
  end

  assign ent_tile   = byp ? byp_tile : rd_tile;
  assign ent_thresh = byp ? byp_thresh : rd_thresh;

  assign cur_valid = valid_bits[s1_addr];
  assign ent_valid = cur_valid;

  // Running count of valid entries.
  always_comb begin
    valid_total_next = valid_total;
    if (cmd.clr_all) begin
      valid_total_next = '0;
    end else if (cmd.wr_en && !cur_valid) begin
      valid_total_next = valid_total + CNT_W'(1);
    end else if (cmd.clr_en && cur_valid) begin
      valid_total_next = valid_total - CNT_W'(1);
    end
  end

  // Valid bits and count, cleared at reset and by a clear-all.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits  <= '0;
      valid_total <= '0;
    end else begin
      valid_total <= valid_total_next;
      if (cmd.clr_all) begin
        valid_bits <= '0;
      end else if (cmd.wr_en) begin
        valid_bits[s1_addr] <= 1'b1;
      end else if (cmd.clr_en) begin
        valid_bits[s1_addr] <= 1'b0;
      end
    end
  end

endmodule

/* verif/class_route_table_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for class_route_table_unit: directed and random operations,
// with random idle cycles on both stream sides and one long output hold-off.
// Depends on crt_pkg and class_route_table_unit.
module class_route_table_unit_tb;
  import crt_pkg::*;

  localparam int NCLASS      = CLASS_COUNT_DEF;
  localparam int NTILE       = TILE_COUNT_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  // Opcode 7 has no operation behind it; the block only reports its statistics.
  localparam logic [2:0] OP_NOP = 3'd7;

  // One result beat, split into its fields.
  typedef struct packed {
    logic [TOUT_W-1:0]  tile;
    logic               routed;
    logic               err;
    logic [CNT32_W-1:0] hits;
    logic [CNT32_W-1:0] misses;
    logic [CNT32_W-1:0] fallbacks;
    logic [TOTAL_W-1:0] total;
    logic [VCNT_W-1:0]  valid_cnt;
    logic [CNT32_W-1:0] version;
  } route_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic [2:0]       s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  // Shadow copy of the routing table and its statistics.
  logic               tbl_valid [NCLASS];
  logic [TOUT_W-1:0]  tbl_tile [NCLASS];
  logic [CONF_W-1:0]  tbl_thresh [NCLASS];
  logic [CNT32_W-1:0] n_hits;
  logic [CNT32_W-1:0] n_misses;
  logic [CNT32_W-1:0] n_fallbacks;
  int                 n_valid;
  logic [CNT32_W-1:0] tbl_version;

  route_result_t route_expect_q [$];

  // Run bookkeeping.
  int  beats_sent = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  failures = 0;
  int  cycles = 0;
  int  lookups_done = 0;
  int  routed_done = 0;
  int  rejected_done = 0;
  int  peak_valid = 0;
  int  input_stall_cycles = 0;
  bit  tx_idle_on = 1'b0;
  bit  rx_idle_on = 1'b0;
  int  hold_asked = 0;
  int  hold_taken = 0;
  int  hold_left = 0;
  int  rx_gap_left = 0;

  class_route_table_unit #(
    .CLASS_COUNT(NCLASS),
    .TILE_COUNT (NTILE)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clears the shadow table to its state after reset.
  task automatic clear_shadow();
    for (int i = 0; i < NCLASS; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_tile[i]   = '0;
      tbl_thresh[i] = '0;
    end
    n_hits      = '0;
    n_misses    = '0;
    n_fallbacks = '0;
    n_valid     = 0;
    tbl_version = '0;
  endtask

  // Applies one operation to the shadow table and returns the beat the block must send.
  function automatic route_result_t predict_route(input logic [2:0] op,
                                                  input logic [CLS_W-1:0] cls,
                                                  input logic [TILE_IN_W-1:0] tile,
                                                  input logic [CONF_W-1:0] conf);
    route_result_t res;
    bit            in_range;
    res      = '0;
    in_range = (cls < NCLASS);
    case (op)
      OP_LOOKUP: begin
        lookups_done++;
        if (!in_range || !tbl_valid[cls]) begin
          if (n_fallbacks != CNT_MAX) n_fallbacks++;
        end else if (conf >= tbl_thresh[cls]) begin
          if (n_hits != CNT_MAX) n_hits++;
          res.tile   = tbl_tile[cls];
          res.routed = 1'b1;
          routed_done++;
        end else begin
          if (n_misses != CNT_MAX) n_misses++;
        end
      end
      OP_WRITE_ENTRY: begin
        if (!in_range || tile >= NTILE) begin
          res.err = 1'b1;
          rejected_done++;
        end else begin
          if (!tbl_valid[cls]) n_valid++;
          tbl_valid[cls]  = 1'b1;
          tbl_tile[cls]   = tile[TOUT_W-1:0];
          tbl_thresh[cls] = conf;
        end
      end
      OP_CLEAR_ENTRY: begin
        if (in_range && tbl_valid[cls]) begin
          tbl_valid[cls] = 1'b0;
          n_valid--;
        end
      end
      OP_CLEAR_ALL: begin
        for (int i = 0; i < NCLASS; i++) tbl_valid[i] = 1'b0;
        n_valid = 0;
        tbl_version++;
      end
      OP_RESET_COUNTERS: begin
        n_hits      = '0;
        n_misses    = '0;
        n_fallbacks = '0;
      end
      OP_END_PASS: begin
        tbl_version++;
      end
      default: begin
      end
    endcase
    if (n_valid > peak_valid) peak_valid = n_valid;
    res.hits      = n_hits;
    res.misses    = n_misses;
    res.fallbacks = n_fallbacks;
    res.total     = TOTAL_W'(n_hits) + TOTAL_W'(n_misses) + TOTAL_W'(n_fallbacks);
    res.valid_cnt = VCNT_W'(n_valid);
    res.version   = tbl_version;
    return res;
  endfunction

  // Offers one beat and waits for the block to take it. Valid stays high afterwards so
  // that a following beat can go out on the next cycle.
  task automatic send_beat(input logic [2:0] op, input logic [CLS_W-1:0] cls,
                           input logic [TILE_IN_W-1:0] tile, input logic [CONF_W-1:0] conf);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, conf, tile, cls};
    do @(posedge clk); while (!s_tready);
    route_expect_q.push_back(predict_route(op, cls, tile, conf));
    beats_sent++;
  endtask

  // Random idle cycles on the input side, mostly short with an occasional long one.
  task automatic sender_gap();
    int len;
    if (tx_idle_on && $urandom_range(0, 99) < 35) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // Lowers valid and waits until every predicted beat has come back.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (route_expect_q.size() != 0) @(posedge clk);
  endtask

  // Draws one random operation. Lookups on valid entries use a confidence close to the
  // stored threshold so that both hits and misses occur often.
  task automatic random_beat(output logic [2:0] op, output logic [CLS_W-1:0] cls,
                             output logic [TILE_IN_W-1:0] tile, output logic [CONF_W-1:0] conf);
    int r;
    int c;
    r = $urandom_range(0, 99);
    if (r < 45)      op = OP_LOOKUP;
    else if (r < 70) op = OP_WRITE_ENTRY;
    else if (r < 78) op = OP_CLEAR_ENTRY;
    else if (r < 80) op = OP_CLEAR_ALL;
    else if (r < 83) op = OP_RESET_COUNTERS;
    else if (r < 92) op = OP_READ_STATS;
    else if (r < 98) op = OP_END_PASS;
    else             op = OP_NOP;
    cls  = ($urandom_range(0, 9) == 0) ? CLS_W'($urandom_range(NCLASS, 255))
                                       : CLS_W'($urandom_range(0, NCLASS-1));
    tile = ($urandom_range(0, 11) == 0) ? TILE_IN_W'($urandom_range(NTILE, 255))
                                        : TILE_IN_W'($urandom_range(0, NTILE-1));
    if (op == OP_LOOKUP && cls < NCLASS && tbl_valid[cls] && $urandom_range(0, 3) != 0) begin
      c = int'(tbl_thresh[cls]) + int'($urandom_range(0, 6)) - 3;
      if (c < 0) c = 0;
      if (c > 131071) c = 131071;
      conf = CONF_W'(c);
    end else begin
      case ($urandom_range(0, 9))
        0:       conf = CONF_W'($urandom_range(0, 131071));
        1:       conf = 17'd65536;
        2:       conf = '0;
        default: conf = CONF_W'($urandom_range(0, 65536));
      endcase
    end
  endtask

  // Field extremes, every operation and the corner cases of lookup, write and clear.
  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_beat(OP_LOOKUP, 8'd0, 8'd0, 17'd0);             // empty table falls back
    send_beat(OP_WRITE_ENTRY, 8'd0, 8'd0, 17'd0);
    sender_gap();
    send_beat(OP_WRITE_ENTRY, 8'd63, 8'd15, 17'd65536);
    send_beat(OP_LOOKUP, 8'd63, 8'd0, 17'd65535);        // just under threshold
    send_beat(OP_LOOKUP, 8'd63, 8'd0, 17'd65536);        // exactly at threshold
    sender_gap();
    send_beat(OP_LOOKUP, 8'd63, 8'd255, 17'h1FFFF);      // confidence above 1.0
    send_beat(OP_WRITE_ENTRY, 8'd1, 8'd9, 17'h1FFFF);    // threshold above 1.0
    send_beat(OP_LOOKUP, 8'd1, 8'd0, 17'd65536);
    send_beat(OP_LOOKUP, 8'd1, 8'd0, 17'h1FFFF);
    // Rejected writes change nothing.
    send_beat(OP_WRITE_ENTRY, 8'd64, 8'd3, 17'd5);
    send_beat(OP_WRITE_ENTRY, 8'd255, 8'd3, 17'd5);
    send_beat(OP_WRITE_ENTRY, 8'd2, 8'd16, 17'd5);
    send_beat(OP_WRITE_ENTRY, 8'd2, 8'd255, 17'd5);
    sender_gap();
    // Rewrite of a valid entry keeps the valid count.
    send_beat(OP_WRITE_ENTRY, 8'd0, 8'd7, 17'd100);
    send_beat(OP_LOOKUP, 8'd0, 8'd0, 17'd99);
    send_beat(OP_LOOKUP, 8'd0, 8'd0, 17'd100);
    send_beat(OP_LOOKUP, 8'd200, 8'd0, 17'd100);         // class out of range
    send_beat(OP_CLEAR_ENTRY, 8'd5, 8'd0, 17'd0);        // already invalid
    send_beat(OP_CLEAR_ENTRY, 8'd200, 8'd0, 17'd0);      // out of range
    send_beat(OP_CLEAR_ENTRY, 8'd0, 8'd0, 17'd0);
    send_beat(OP_LOOKUP, 8'd0, 8'd0, 17'd65536);
    send_beat(OP_READ_STATS, 8'd0, 8'd0, 17'd0);
    send_beat(OP_END_PASS, 8'd0, 8'd0, 17'd0);
    send_beat(OP_NOP, 8'd17, 8'd4, 17'd123);
    send_beat(OP_RESET_COUNTERS, 8'd0, 8'd0, 17'd0);
    send_beat(OP_CLEAR_ALL, 8'd0, 8'd0, 17'd0);
    send_beat(OP_LOOKUP, 8'd63, 8'd0, 17'h1FFFF);
    wait_drain();
  endtask

  // Fills every entry so the valid count reaches its top, probes it, then clears all.
  task automatic test_full_table();
    logic [2:0]           op;
    logic [CLS_W-1:0]     cls;
    logic [TILE_IN_W-1:0] tile;
    logic [CONF_W-1:0]    conf;
    for (int i = 0; i < NCLASS; i++) begin
      send_beat(OP_WRITE_ENTRY, CLS_W'(i), TILE_IN_W'($urandom_range(0, NTILE-1)),
                CONF_W'($urandom_range(0, 65536)));
      sender_gap();
    end
    for (int i = 0; i < 12; i++) begin
      random_beat(op, cls, tile, conf);
      send_beat(OP_LOOKUP, cls, tile, conf);
      sender_gap();
    end
    send_beat(OP_CLEAR_ALL, 8'd0, 8'd0, 17'd0);
    wait_drain();
  endtask

  // Holds the output off for a long stretch while beats keep coming, so the block
  // fills and stalls its input, then lets everything drain before going on.
  task automatic test_backpressure();
    logic [2:0]           op;
    logic [CLS_W-1:0]     cls;
    logic [TILE_IN_W-1:0] tile;
    logic [CONF_W-1:0]    conf;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_asked++;
    for (int i = 0; i < 30; i++) begin
      random_beat(op, cls, tile, conf);
      send_beat(op, cls, tile, conf);
    end
    wait_drain();
  endtask

  // Random traffic in batches; each batch turns idling on either side on or off.
  task automatic test_random(input int n_beats);
    logic [2:0]           op;
    logic [CLS_W-1:0]     cls;
    logic [TILE_IN_W-1:0] tile;
    logic [CONF_W-1:0]    conf;
    for (int i = 0; i < n_beats; i++) begin
      if (i % 50 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      random_beat(op, cls, tile, conf);
      send_beat(op, cls, tile, conf);
      sender_gap();
    end
    wait_drain();
  endtask

  // Output side: random stalls, plus the long hold-off when a test asks for it.
  always @(posedge clk) begin
    if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES - 1;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      m_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
      rx_gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic compare_field(input string fname, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      failures++;
      if (mismatches <= MAX_REPORTS)
        $display("Mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                 results_seen, fname, want, got);
    end
  endtask

  // Checks every result beat against the oldest prediction.
  always @(posedge clk) begin
    route_result_t want;
    if (!rst && s_tvalid && !s_tready) input_stall_cycles++;
    if (!rst && m_tvalid && m_tready) begin
      if (route_expect_q.size() == 0) begin
        mismatches++;
        failures++;
        if (mismatches <= MAX_REPORTS)
          $display("Result beat 0x%0h arrived with nothing expected", m_tdata);
      end else begin
        want = route_expect_q.pop_front();
        compare_field("tile_out", TOTAL_W'(want.tile), TOTAL_W'(m_tdata[3:0]));
        compare_field("compiled_route", TOTAL_W'(want.routed), TOTAL_W'(m_tdata[4]));
        compare_field("op_error", TOTAL_W'(want.err), TOTAL_W'(m_tdata[5]));
        compare_field("hit_count", TOTAL_W'(want.hits), TOTAL_W'(m_tdata[37:6]));
        compare_field("miss_count", TOTAL_W'(want.misses), TOTAL_W'(m_tdata[69:38]));
        compare_field("fallback_count", TOTAL_W'(want.fallbacks),
                      TOTAL_W'(m_tdata[101:70]));
        compare_field("total_count", want.total, m_tdata[135:102]);
        compare_field("valid_entries", TOTAL_W'(want.valid_cnt),
                      TOTAL_W'(m_tdata[142:136]));
        compare_field("table_version", TOTAL_W'(want.version), TOTAL_W'(m_tdata[174:143]));
      end
      results_seen++;
    end
  end

  // Watchdog: ends a run that hangs.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding",
             cycles, route_expect_q.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    clear_shadow();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random(450);
    repeat (8) @(posedge clk);
    if (route_expect_q.size() != 0) begin
      $display("%0d expected results never arrived", route_expect_q.size());
    end
    $display("Sent %0d beats and checked %0d results: %0d lookups, %0d routed, %0d rejected writes.",
             beats_sent, results_seen, lookups_done, routed_done, rejected_done);
    $display("Peak of %0d valid entries; input stalled for %0d cycles; %0d field mismatches.",
             peak_valid, input_stall_cycles, mismatches);
    if (failures == 0 && route_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/crt_pkg.sv
rtl/crt_entry_store.sv
rtl/class_route_table_unit.sv
verif/class_route_table_unit_tb.sv
